>>> src/ssno_pkg.sv
// Shared constants, types and the digit-to-segment table for the seven-segment overlay.
// No dependencies; imported by seven_segment_number_overlay_unit.
package ssno_pkg;

	// Default frame size
	localparam int IMAGE_WIDTH_DEF  = 512;
	localparam int IMAGE_HEIGHT_DEF = 512;

	// Field widths
	localparam int COORD_W  = 9;
	localparam int PIXEL_W  = 16;
	localparam int NUMBER_W = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 40;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SHOWN_NUMBER  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_COLOR = 1'd1;

	// Largest number that can be drawn
	localparam logic [NUMBER_W-1:0] NUMBER_MAX = 10'd999;

	// Digit geometry: offsets subtracted from the frame width or height
	localparam int DIGIT_SPACING = 22;
	localparam int ROW_TOP_LO = 42;
	localparam int ROW_UP_LO  = 39;
	localparam int ROW_MID_LO = 27;
	localparam int ROW_LOW_LO = 24;
	localparam int ROW_BOT_LO = 12;
	localparam int ROW_BOT_HI = 9;
	localparam int COL_LEFT_LO  = 27;
	localparam int COL_BAR_LO   = 24;
	localparam int COL_RIGHT_LO = 12;
	localparam int COL_RIGHT_HI = 9;

	// Reciprocal multipliers for the decimal split
	localparam int DIV100_MUL = 41;
	localparam int DIV100_SH  = 12;
	localparam int DIV10_MUL  = 205;
	localparam int DIV10_SH   = 11;

	// Horizontal bands of one digit
	typedef struct packed {
		logic bottom;
		logic lower;
		logic middle;
		logic upper;
		logic top;
	} row_band_t;

	// Column classes of one digit position
	typedef struct packed {
		logic right;
		logic left;
		logic bar;
	} col_class_t;

	// Segment mask of a decimal digit; bit k lights segment k
	// (top, upper left, upper right, middle, lower left, lower right, bottom)
	function automatic logic [6:0] digit_segments(input logic [3:0] digit);
		logic [6:0] m;
		case (digit)
			4'd0: m = 7'h77;
			4'd1: m = 7'h24;
			4'd2: m = 7'h5D;
			4'd3: m = 7'h6D;
			4'd4: m = 7'h2E;
			4'd5: m = 7'h6B;
			4'd6: m = 7'h7A;
			4'd7: m = 7'h25;
			4'd8: m = 7'h7F;
			4'd9: m = 7'h2F;
			default: m = 7'h00;
		endcase
		return m;
	endfunction

endpackage

>>> src/seven_segment_number_overlay_unit.sv
// Overlays a three-digit seven-segment number on a pixel stream, bottom-right corner.
// Depends on ssno_pkg for geometry constants, the segment table and register indexes.
//
//  channel  | direction | beat contents
//  ---------+-----------+---------------------------------------------------------
//  s_axis   | in        | tdata: pixel_col[8:0], pixel_row[17:9], pixel_in[33:18]
//  m_axis   | out       | tdata: pixel_out[15:0]; tuser: in_segment
//  cfg      | in        | cfg_we, cfg_index, cfg_data (no read-back)
//
// Four register stages: one beat enters per cycle unless m_axis stalls.
// Stage 1 saturates the number, splits off hundreds and compares coordinates against
// the band and column limits; stages 2-3 take the remainder and tens; stage 4 finds units and combines.
// A stall on m_axis freezes all stages together; nothing is dropped or repeated.
// Reset clears the valid bits and both configuration registers.
module seven_segment_number_overlay_unit
	import ssno_pkg::*;
#(
	parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // pixel_col, pixel_row, pixel_in, zero pad
	// output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PIXEL_W-1:0]    m_axis_tdata,  // pixel_out
	output logic                  m_axis_tuser   // in_segment
);

	localparam int DIM_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
	localparam int CW_RAW  = $clog2(DIM_MAX + 1);
	localparam int CW      = (CW_RAW > COORD_W) ? CW_RAW : COORD_W;

	// Row limits
	localparam logic [CW-1:0] R_TOP = CW'(IMAGE_HEIGHT - ROW_TOP_LO);
	localparam logic [CW-1:0] R_UP  = CW'(IMAGE_HEIGHT - ROW_UP_LO);
	localparam logic [CW-1:0] R_MID = CW'(IMAGE_HEIGHT - ROW_MID_LO);
	localparam logic [CW-1:0] R_LOW = CW'(IMAGE_HEIGHT - ROW_LOW_LO);
	localparam logic [CW-1:0] R_BOT = CW'(IMAGE_HEIGHT - ROW_BOT_LO);
	localparam logic [CW-1:0] R_END = CW'(IMAGE_HEIGHT - ROW_BOT_HI);

	// Configuration registers
	logic [NUMBER_W-1:0] shown_number_q;
	logic [PIXEL_W-1:0]  overlay_color_q;

	// Pipeline advance
	logic en;

	// Input unpacking
	logic [COORD_W-1:0] in_col;
	logic [COORD_W-1:0] in_row;
	logic [PIXEL_W-1:0] in_pix;
	logic [CW-1:0]      col_x;
	logic [CW-1:0]      row_x;

	// Stage 1 logic
	logic [NUMBER_W-1:0] n_sat;
	logic [15:0]         h_prod;
	row_band_t           band_c;
	col_class_t [2:0]    cls_c;

	// Stage registers
	logic                v_s1, v_s2, v_s3, v_s4;
	logic [PIXEL_W-1:0]  pix_s1, pix_s2, pix_s3;
	row_band_t           band_s1, band_s2, band_s3;
	col_class_t [2:0]    cls_s1, cls_s2, cls_s3;
	logic [NUMBER_W-1:0] n_s1;
	logic [3:0]          hund_s1, hund_s2, hund_s3;
	logic [6:0]          rem_s2, rem_s3;
	logic [3:0]          tens_s3;
	logic [PIXEL_W-1:0]  pix_s4;
	logic                hit_s4;

	// Stage 2/3/4 logic
	logic [NUMBER_W-1:0] rem_full;
	logic [14:0]         t_prod;
	logic [6:0]          tens_x10;
	logic [6:0]          units_full;
	logic [3:0]          units;
	logic [6:0]          mask_h, mask_t, mask_u;
	logic                show_h, show_t;
	logic [2:0]          pos_hit;

	// Lit segment under the pixel for one digit position
	function automatic logic seg_hit(input logic [6:0] m, input row_band_t b,
		input col_class_t c);
		logic r;
		r = (m[0] && b.top    && c.bar)   ||
		    (m[1] && b.upper  && c.left)  ||
		    (m[2] && b.upper  && c.right) ||
		    (m[3] && b.middle && c.bar)   ||
		    (m[4] && b.lower  && c.left)  ||
		    (m[5] && b.lower  && c.right) ||
		    (m[6] && b.bottom && c.bar);
		return r;
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_number_q  <= '0;
			overlay_color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHOWN_NUMBER:  shown_number_q  <= cfg_data[NUMBER_W-1:0];
				CFG_OVERLAY_COLOR: overlay_color_q <= cfg_data[PIXEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance whenever the output slot is free or being taken
	assign en            = !v_s4 || m_axis_tready;
	assign s_axis_tready = en;

	assign in_col = s_axis_tdata[COORD_W-1:0];
	assign in_row = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign in_pix = s_axis_tdata[2*COORD_W+PIXEL_W-1:2*COORD_W];
	assign col_x  = CW'(in_col);
	assign row_x  = CW'(in_row);

	// Stage 1: saturate, divide by 100, classify coordinates
	always_comb begin
		n_sat  = (shown_number_q > NUMBER_MAX) ? NUMBER_MAX : shown_number_q;
		h_prod = 16'(n_sat) * 16'(DIV100_MUL);

		band_c.top    = (row_x >= R_TOP) && (row_x < R_UP);
		band_c.upper  = (row_x >= R_UP)  && (row_x < R_MID);
		band_c.middle = (row_x >= R_MID) && (row_x < R_LOW);
		band_c.lower  = (row_x >= R_LOW) && (row_x < R_BOT);
		band_c.bottom = (row_x >= R_BOT) && (row_x < R_END);

		for (int p = 0; p < 3; p++) begin
			cls_c[p].left  = (col_x >= CW'(IMAGE_WIDTH - COL_LEFT_LO - p*DIGIT_SPACING)) &&
			                 (col_x <  CW'(IMAGE_WIDTH - COL_BAR_LO - p*DIGIT_SPACING));
			cls_c[p].bar   = (col_x >= CW'(IMAGE_WIDTH - COL_BAR_LO - p*DIGIT_SPACING)) &&
			                 (col_x <  CW'(IMAGE_WIDTH - COL_RIGHT_LO - p*DIGIT_SPACING));
			cls_c[p].right = (col_x >= CW'(IMAGE_WIDTH - COL_RIGHT_LO - p*DIGIT_SPACING)) &&
			                 (col_x <  CW'(IMAGE_WIDTH - COL_RIGHT_HI - p*DIGIT_SPACING));
		end
	end

	// Stage 2: remainder after hundreds
	assign rem_full = n_s1 - NUMBER_W'(hund_s1) * NUMBER_W'(100);

	// Stage 3: divide remainder by 10
	assign t_prod = 15'(rem_s2) * 15'(DIV10_MUL);

	// Stage 4: units, segment lookup and hit test
	always_comb begin
		tens_x10   = (7'(tens_s3) << 3) + (7'(tens_s3) << 1);
		units_full = rem_s3 - tens_x10;
		units      = units_full[3:0];
		mask_h     = digit_segments(hund_s3);
		mask_t     = digit_segments(tens_s3);
		mask_u     = digit_segments(units);
		show_h     = (hund_s3 != 4'd0);
		show_t     = show_h || (tens_s3 != 4'd0);
		pos_hit[0] = seg_hit(mask_u, band_s3, cls_s3[0]);
		pos_hit[1] = show_t && seg_hit(mask_t, band_s3, cls_s3[1]);
		pos_hit[2] = show_h && seg_hit(mask_h, band_s3, cls_s3[2]);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Payload stages; hold on stall
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1  <= in_pix;
			band_s1 <= band_c;
			cls_s1  <= cls_c;
			n_s1    <= n_sat;
			hund_s1 <= h_prod[DIV100_SH+3:DIV100_SH];

			pix_s2  <= pix_s1;
			band_s2 <= band_s1;
			cls_s2  <= cls_s1;
			hund_s2 <= hund_s1;
			rem_s2  <= rem_full[6:0];

			pix_s3  <= pix_s2;
			band_s3 <= band_s2;
			cls_s3  <= cls_s2;
			hund_s3 <= hund_s2;
			rem_s3  <= rem_s2;
			tens_s3 <= t_prod[DIV10_SH+3:DIV10_SH];

			hit_s4  <= |pos_hit;
			pix_s4  <= (|pos_hit) ? overlay_color_q : pix_s3;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = pix_s4;
	assign m_axis_tuser  = hit_s4;

endmodule
